@@ hw/rtl/cknms_pkg.sv @@
// Shared constants, codes and types for the corner keypoint table.
package cknms_pkg;

   localparam int MAX_KEYPOINTS = 1024;
   localparam int COORD_BITS    = 11;
   localparam int SLOT_BITS     = $clog2(MAX_KEYPOINTS);
   localparam int COUNT_BITS    = SLOT_BITS + 1;
   localparam int RESP_BITS     = 8;
   localparam int DIAM_BITS     = 6;
   localparam int DSQ_BITS      = 2 * DIAM_BITS;
   localparam int SQ_BITS       = 2 * COORD_BITS;
   localparam int ACTION_BITS   = 2;
   localparam int OUTCOME_BITS  = 3;
   localparam int SLOT_OUT_BITS = 10;
   localparam int CNT_OUT_BITS  = 11;

   localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_OFFER = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_READ  = 2'd2;

   localparam logic [OUTCOME_BITS-1:0] OUT_CLEARED    = 3'd0;
   localparam logic [OUTCOME_BITS-1:0] OUT_BELOW      = 3'd1;
   localparam logic [OUTCOME_BITS-1:0] OUT_ADDED      = 3'd2;
   localparam logic [OUTCOME_BITS-1:0] OUT_REPLACED   = 3'd3;
   localparam logic [OUTCOME_BITS-1:0] OUT_SUPPRESSED = 3'd4;
   localparam logic [OUTCOME_BITS-1:0] OUT_FULL       = 3'd5;
   localparam logic [OUTCOME_BITS-1:0] OUT_READ_OK    = 3'd6;
   localparam logic [OUTCOME_BITS-1:0] OUT_BAD_INDEX  = 3'd7;

   localparam logic [RESP_BITS-1:0] THRESHOLD_RESET = 8'd100;
   localparam logic [DIAM_BITS-1:0] DIAMETER_RESET  = 6'd6;

   localparam int                   CSR_ADDR_BITS  = 3;
   localparam int                   CSR_DATA_BITS  = 32;
   localparam logic                 REG_THRESHOLD  = 1'b0;
   localparam logic                 REG_DIAMETER   = 1'b1;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [RESP_BITS-1:0]  resp;
   } entry_type;

endpackage

@@ hw/rtl/cknms_req_if.sv @@
// Request channel interface of the corner keypoint table.
interface cknms_req_if import cknms_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [ACTION_BITS-1:0]   action;
   logic [COORD_BITS-1:0]    pixel_x;
   logic [COORD_BITS-1:0]    pixel_y;
   logic [RESP_BITS-1:0]     pixel_response;
   logic [SLOT_OUT_BITS-1:0] read_slot;

   modport source (output valid, action, pixel_x, pixel_y, pixel_response, read_slot,
                   input ready);
   modport sink   (input valid, action, pixel_x, pixel_y, pixel_response, read_slot,
                   output ready);
endinterface

@@ hw/rtl/cknms_rsp_if.sv @@
// Response channel interface of the corner keypoint table.
interface cknms_rsp_if import cknms_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OUTCOME_BITS-1:0]  outcome;
   logic [SLOT_OUT_BITS-1:0] slot;
   logic [CNT_OUT_BITS-1:0]  entry_count;
   logic [COORD_BITS-1:0]    entry_x;
   logic [COORD_BITS-1:0]    entry_y;
   logic [RESP_BITS-1:0]     entry_response;

   modport source (output valid, outcome, slot, entry_count, entry_x, entry_y, entry_response,
                   input ready);
   modport sink   (input valid, outcome, slot, entry_count, entry_x, entry_y, entry_response,
                   output ready);
endinterface

@@ hw/rtl/corner_keypoint_nms_table.sv @@
// Top level of the corner keypoint table with non-maximum suppression.
//
// Usage: each request transaction on req_if carries one action: clear the
// table, offer a corner pixel, or read a stored entry. Every request gives
// exactly one response transaction on rsp_if with the outcome, slot, entry
// count and, for reads, the stored entry. The APB port writes the response
// threshold (0x0) and keypoint diameter (0x4); psel/penable/pwrite write in
// the access cycle, pready is always high.
// Flow: clear, below-threshold and bad-index requests and an offer into an empty
// table go from idle straight to the done state; reads pass through the read
// state; an offered pixel above the threshold walks the stored entries, ending
// early when an entry is replaced: the walk reads one entry per cycle from the
// table memory through a two-stage distance pipeline.
// One request is in flight at a time; the next one can be accepted in the cycle
// after the response is loaded into the output register.
// req_if.ready is high while the block is idle, also while a finished response
// waits in the output register. If the receiver stalls, the next response holds
// in the block until the output register drains. Reset empties the table and
// restores the register defaults; the memory itself is not cleared.
module corner_keypoint_nms_table import cknms_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   cknms_req_if.sink                req_if,
   cknms_rsp_if.source              rsp_if,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [RESP_BITS-1:0]     thr_ff, thr_in;
   logic [DIAM_BITS-1:0]     diam_ff, diam_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [COORD_BITS-1:0]    px_ff, px_in, py_ff, py_in;
   logic [RESP_BITS-1:0]     pr_ff, pr_in;
   logic [DSQ_BITS-1:0]      dsq_ff, dsq_in;
   logic [COUNT_BITS-1:0]    rd_cnt_ff, rd_cnt_in;
   logic                     va_ff, va_in, vb_ff, vb_in;
   logic [SLOT_BITS-1:0]     a_idx_ff, a_idx_in, b_idx_ff, b_idx_in;
   logic [SQ_BITS-1:0]       sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [RESP_BITS-1:0]     b_resp_ff, b_resp_in;
   logic                     ovl_ff, ovl_in;
   logic [OUTCOME_BITS-1:0]  res_outcome_ff, res_outcome_in;
   logic [SLOT_BITS-1:0]     res_slot_ff, res_slot_in;
   entry_type                res_entry_ff, res_entry_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OUTCOME_BITS-1:0]  rsp_outcome_ff, rsp_outcome_in;
   logic [SLOT_BITS-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;
   entry_type                rsp_entry_ff, rsp_entry_in;

   entry_type                mem [MAX_KEYPOINTS];
   entry_type                mem_q;
   logic                     mem_we;
   logic [SLOT_BITS-1:0]     mem_waddr, mem_raddr;
   entry_type                mem_wdata;

   logic                     req_fire, csr_write;
   logic [COORD_BITS-1:0]    dx, dy;
   logic [SQ_BITS:0]         dist_sq;
   logic                     hit, better, last;

   assign req_fire  = req_if.valid && req_if.ready;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_DIAMETER) ?
                      CSR_DATA_BITS'(diam_ff) : CSR_DATA_BITS'(thr_ff);

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.outcome        = rsp_outcome_ff;
   assign rsp_if.slot           = SLOT_OUT_BITS'(rsp_slot_ff);
   assign rsp_if.entry_count    = CNT_OUT_BITS'(rsp_count_ff);
   assign rsp_if.entry_x        = rsp_entry_ff.x;
   assign rsp_if.entry_y        = rsp_entry_ff.y;
   assign rsp_if.entry_response = rsp_entry_ff.resp;

   assign dx      = (px_ff > mem_q.x) ? (px_ff - mem_q.x) : (mem_q.x - px_ff);
   assign dy      = (py_ff > mem_q.y) ? (py_ff - mem_q.y) : (mem_q.y - py_ff);
   assign dist_sq = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign hit     = dist_sq < (SQ_BITS + 1)'(dsq_ff);
   assign better  = pr_ff > b_resp_ff;
   assign last    = {1'b0, b_idx_ff} == (count_ff - COUNT_BITS'(1));

   always_comb begin
      state_in       = state_ff;
      thr_in         = thr_ff;
      diam_in        = diam_ff;
      count_in       = count_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      pr_in          = pr_ff;
      dsq_in         = dsq_ff;
      rd_cnt_in      = rd_cnt_ff;
      va_in          = 1'b0;
      vb_in          = 1'b0;
      a_idx_in       = a_idx_ff;
      b_idx_in       = b_idx_ff;
      sqx_in         = sqx_ff;
      sqy_in         = sqy_ff;
      b_resp_in      = b_resp_ff;
      ovl_in         = ovl_ff;
      res_outcome_in = res_outcome_ff;
      res_slot_in    = res_slot_ff;
      res_entry_in   = res_entry_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_entry_in   = rsp_entry_ff;
      mem_we         = 1'b0;
      mem_waddr      = count_ff[SLOT_BITS-1:0];
      mem_wdata      = '{x: px_ff, y: py_ff, resp: pr_ff};
      mem_raddr      = rd_cnt_ff[SLOT_BITS-1:0];

      if (csr_write) begin
         if (paddr[2] == REG_DIAMETER) begin
            diam_in = pwdata[DIAM_BITS-1:0];
         end else begin
            thr_in = pwdata[RESP_BITS-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            mem_raddr = SLOT_BITS'(req_if.read_slot);
            if (req_fire) begin
               px_in          = req_if.pixel_x;
               py_in          = req_if.pixel_y;
               pr_in          = req_if.pixel_response;
               dsq_in         = DSQ_BITS'(diam_ff) * DSQ_BITS'(diam_ff);
               res_slot_in    = '0;
               res_entry_in   = '0;
               res_outcome_in = OUT_BAD_INDEX;
               state_in       = ST_DONE;
               case (req_if.action)
                  ACT_CLEAR: begin
                     count_in       = '0;
                     res_outcome_in = OUT_CLEARED;
                  end
                  ACT_OFFER: begin
                     if (req_if.pixel_response <= thr_ff) begin
                        res_outcome_in = OUT_BELOW;
                     end else if (count_ff == '0) begin
                        mem_we         = 1'b1;
                        mem_wdata      = '{x: req_if.pixel_x, y: req_if.pixel_y,
                                           resp: req_if.pixel_response};
                        count_in       = COUNT_BITS'(1);
                        res_outcome_in = OUT_ADDED;
                     end else begin
                        rd_cnt_in = '0;
                        ovl_in    = 1'b0;
                        state_in  = ST_WALK;
                     end
                  end
                  ACT_READ: begin
                     if (COUNT_BITS'(req_if.read_slot) < count_ff) begin
                        res_slot_in = SLOT_BITS'(req_if.read_slot);
                        state_in    = ST_READ;
                     end
                  end
                  default: begin
                     res_outcome_in = OUT_BAD_INDEX;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (rd_cnt_ff < count_ff) begin
               va_in     = 1'b1;
               a_idx_in  = rd_cnt_ff[SLOT_BITS-1:0];
               rd_cnt_in = rd_cnt_ff + COUNT_BITS'(1);
            end
            vb_in     = va_ff;
            b_idx_in  = a_idx_ff;
            sqx_in    = SQ_BITS'(dx) * SQ_BITS'(dx);
            sqy_in    = SQ_BITS'(dy) * SQ_BITS'(dy);
            b_resp_in = mem_q.resp;
            if (vb_ff) begin
               ovl_in = ovl_ff || hit;
               if (hit && better) begin
                  mem_we         = 1'b1;
                  mem_waddr      = b_idx_ff;
                  res_outcome_in = OUT_REPLACED;
                  res_slot_in    = b_idx_ff;
                  va_in          = 1'b0;
                  vb_in          = 1'b0;
                  state_in       = ST_DONE;
               end else if (last) begin
                  va_in    = 1'b0;
                  vb_in    = 1'b0;
                  state_in = ST_DONE;
                  if (hit || ovl_ff) begin
                     res_outcome_in = OUT_SUPPRESSED;
                  end else if (count_ff == COUNT_BITS'(MAX_KEYPOINTS)) begin
                     res_outcome_in = OUT_FULL;
                  end else begin
                     mem_we         = 1'b1;
                     count_in       = count_ff + COUNT_BITS'(1);
                     res_outcome_in = OUT_ADDED;
                     res_slot_in    = count_ff[SLOT_BITS-1:0];
                  end
               end
            end
         end
         ST_READ: begin
            res_entry_in   = mem_q;
            res_outcome_in = OUT_READ_OK;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = res_outcome_ff;
               rsp_slot_in    = res_slot_ff;
               rsp_count_in   = count_ff;
               rsp_entry_in   = res_entry_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THRESHOLD_RESET;
         diam_ff      <= DIAMETER_RESET;
         count_ff     <= '0;
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         diam_ff      <= diam_in;
         count_ff     <= count_in;
         va_ff        <= va_in;
         vb_ff        <= vb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff          <= px_in;
      py_ff          <= py_in;
      pr_ff          <= pr_in;
      dsq_ff         <= dsq_in;
      rd_cnt_ff      <= rd_cnt_in;
      a_idx_ff       <= a_idx_in;
      b_idx_ff       <= b_idx_in;
      sqx_ff         <= sqx_in;
      sqy_ff         <= sqy_in;
      b_resp_ff      <= b_resp_in;
      ovl_ff         <= ovl_in;
      res_outcome_ff <= res_outcome_in;
      res_slot_ff    <= res_slot_in;
      res_entry_ff   <= res_entry_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_entry_ff   <= rsp_entry_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_KEYPOINTS))
      else $error("entry count above table depth");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted request did not start work");

   a_walk_write_stage: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == ST_WALK) |-> vb_ff)
      else $error("table written during walk without a compared entry");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished result not loaded into output register");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> count_ff != '0)
      else $error("walk started on an empty table");

endmodule

@@ dv/cknms_checker.sv @@
`timescale 1ns / 1ps
// Checker for the corner keypoint table: tracks the table and compares every response.
module cknms_checker import cknms_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   cknms_req_if                     req_mon,
   cknms_rsp_if                     rsp_mon,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic                     pready,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output int                       outstanding,
   output int                       mismatches
);

   typedef struct packed {
      logic [OUTCOME_BITS-1:0]  outcome;
      logic [SLOT_OUT_BITS-1:0] slot;
      logic [CNT_OUT_BITS-1:0]  count;
      logic [COORD_BITS-1:0]    x;
      logic [COORD_BITS-1:0]    y;
      logic [RESP_BITS-1:0]     resp;
   } keypoint_result_type;

   logic [COORD_BITS-1:0] kp_x    [MAX_KEYPOINTS];
   logic [COORD_BITS-1:0] kp_y    [MAX_KEYPOINTS];
   logic [RESP_BITS-1:0]  kp_resp [MAX_KEYPOINTS];
   int                    kp_count;
   logic [RESP_BITS-1:0]  threshold;
   logic [DIAM_BITS-1:0]  diameter;

   keypoint_result_type awaited_results[$];
   keypoint_result_type oldest;

   initial begin
      outstanding = 0;
      mismatches  = 0;
      kp_count    = 0;
      threshold   = THRESHOLD_RESET;
      diameter    = DIAMETER_RESET;
   end

   function automatic keypoint_result_type table_step(
         input logic [ACTION_BITS-1:0]   act,
         input logic [COORD_BITS-1:0]    px,
         input logic [COORD_BITS-1:0]    py,
         input logic [RESP_BITS-1:0]     presp,
         input logic [SLOT_OUT_BITS-1:0] rslot);
      keypoint_result_type r;
      int               i;
      int               dx;
      int               dy;
      int               reach;
      bit               overlap;
      bit               replaced;
      r = '0;
      r.outcome = OUT_BAD_INDEX;
      case (act)
         ACT_CLEAR: begin
            kp_count  = 0;
            r.outcome = OUT_CLEARED;
         end
         ACT_OFFER: begin
            if (presp <= threshold) begin
               r.outcome = OUT_BELOW;
            end else begin
               reach    = int'(diameter) * int'(diameter);
               overlap  = 1'b0;
               replaced = 1'b0;
               for (i = 0; i < kp_count && !replaced; i++) begin
                  dx = int'(px) - int'(kp_x[i]);
                  dy = int'(py) - int'(kp_y[i]);
                  if (dx * dx + dy * dy < reach) begin
                     overlap = 1'b1;
                     if (presp > kp_resp[i]) begin
                        kp_x[i]    = px;
                        kp_y[i]    = py;
                        kp_resp[i] = presp;
                        replaced   = 1'b1;
                        r.slot     = SLOT_OUT_BITS'(i);
                     end
                  end
               end
               if (replaced) begin
                  r.outcome = OUT_REPLACED;
               end else if (overlap) begin
                  r.outcome = OUT_SUPPRESSED;
               end else if (kp_count >= MAX_KEYPOINTS) begin
                  r.outcome = OUT_FULL;
               end else begin
                  kp_x[kp_count]    = px;
                  kp_y[kp_count]    = py;
                  kp_resp[kp_count] = presp;
                  r.slot            = SLOT_OUT_BITS'(kp_count);
                  kp_count++;
                  r.outcome = OUT_ADDED;
               end
            end
         end
         ACT_READ: begin
            if (int'(rslot) < kp_count) begin
               r.outcome = OUT_READ_OK;
               r.slot    = rslot;
               r.x       = kp_x[rslot];
               r.y       = kp_y[rslot];
               r.resp    = kp_resp[rslot];
            end
         end
         default: r.outcome = OUT_BAD_INDEX;
      endcase
      r.count = CNT_OUT_BITS'(kp_count);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kp_count  = 0;
         threshold = THRESHOLD_RESET;
         diameter  = DIAMETER_RESET;
         awaited_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_DIAMETER) begin
               diameter = pwdata[DIAM_BITS-1:0];
            end else begin
               threshold = pwdata[RESP_BITS-1:0];
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            awaited_results = {awaited_results, table_step(req_mon.action, req_mon.pixel_x,
               req_mon.pixel_y, req_mon.pixel_response, req_mon.read_slot)};
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               $error("response transaction with no request waiting");
               mismatches++;
            end else begin
               oldest = awaited_results.pop_front();
               check_field("outcome", 32'(oldest.outcome), 32'(rsp_mon.outcome));
               check_field("slot", 32'(oldest.slot), 32'(rsp_mon.slot));
               check_field("entry_count", 32'(oldest.count), 32'(rsp_mon.entry_count));
               check_field("entry_x", 32'(oldest.x), 32'(rsp_mon.entry_x));
               check_field("entry_y", 32'(oldest.y), 32'(rsp_mon.entry_y));
               check_field("entry_response", 32'(oldest.resp),
                           32'(rsp_mon.entry_response));
            end
         end
      end
      outstanding = awaited_results.size();
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the corner keypoint table: stimulus, backpressure and verdict.
module tb_top import cknms_pkg::*; ();

   localparam logic [ACTION_BITS-1:0] ACT_SPARE = 2'd3;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;
   int                       outstanding;
   int                       mismatches;
   bit                       sender_gaps = 1'b1;
   bit                       receiver_stalls = 1'b1;
   logic [COORD_BITS-1:0]    fill_x [MAX_KEYPOINTS];
   logic [COORD_BITS-1:0]    fill_y [MAX_KEYPOINTS];

   cknms_req_if req_bus();
   cknms_rsp_if rsp_bus();

   corner_keypoint_nms_table u_top (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   cknms_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic push_request(input logic [ACTION_BITS-1:0]   act,
                               input logic [COORD_BITS-1:0]    x,
                               input logic [COORD_BITS-1:0]    y,
                               input logic [RESP_BITS-1:0]     resp,
                               input logic [SLOT_OUT_BITS-1:0] idx);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.action         <= act;
      req_bus.pixel_x        <= x;
      req_bus.pixel_y        <= y;
      req_bus.pixel_response <= resp;
      req_bus.read_slot      <= idx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic sel, input logic [CSR_DATA_BITS-1:0] value);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic apply_setting(input logic [RESP_BITS-1:0] thr, input logic [DIAM_BITS-1:0] diam);
      write_register(REG_THRESHOLD, (32'($urandom) & ~32'hFF) | 32'(thr));
      write_register(REG_DIAMETER, (32'($urandom) & ~32'h3F) | 32'(diam));
   endtask

   task automatic random_phase(input int items, input int span);
      int                    n;
      int                    pick;
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      cx = '0;
      cy = '0;
      for (n = 0; n < items; n++) begin
         if (n % 16 == 0) begin
            cx = COORD_BITS'($urandom_range(0, 2047));
            cy = COORD_BITS'($urandom_range(0, 2047));
         end
         if (n == items / 2) drain();
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            push_request(ACT_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
               RESP_BITS'($urandom), SLOT_OUT_BITS'($urandom));
         end else if (pick < 6) begin
            push_request(ACT_SPARE, COORD_BITS'($urandom), COORD_BITS'($urandom),
               RESP_BITS'($urandom), SLOT_OUT_BITS'($urandom));
         end else if (pick < 25) begin
            push_request(ACT_READ, COORD_BITS'($urandom), COORD_BITS'($urandom),
               RESP_BITS'($urandom),
               SLOT_OUT_BITS'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 48)
                                                          : $urandom_range(0, 1023)));
         end else if (pick < 88) begin
            push_request(ACT_OFFER, cx + COORD_BITS'($urandom_range(0, 2 * span)),
               cy + COORD_BITS'($urandom_range(0, 2 * span)),
               RESP_BITS'($urandom_range(0, 255)), SLOT_OUT_BITS'($urandom));
         end else begin
            push_request(ACT_OFFER, COORD_BITS'($urandom), COORD_BITS'($urandom),
               RESP_BITS'($urandom), SLOT_OUT_BITS'($urandom));
         end
      end
   endtask

   initial begin
      int                   i;
      int                   k;
      logic [RESP_BITS-1:0] thr;
      logic [DIAM_BITS-1:0] diam;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.action         = ACT_CLEAR;
      req_bus.pixel_x        = '0;
      req_bus.pixel_y        = '0;
      req_bus.pixel_response = '0;
      req_bus.read_slot      = '0;
      psel                   = 1'b0;
      penable                = 1'b0;
      pwrite                 = 1'b0;
      paddr                  = '0;
      pwdata                 = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults: threshold 100, diameter 6
      push_request(ACT_READ, 0, 0, 0, 0);
      push_request(ACT_OFFER, 5, 5, 100, 0);
      push_request(ACT_OFFER, 0, 0, 101, 10'h3FF);
      push_request(ACT_OFFER, 2047, 2047, 255, 0);
      push_request(ACT_OFFER, 3, 3, 150, 0);
      push_request(ACT_OFFER, 4, 4, 120, 0);
      push_request(ACT_OFFER, 2041, 2047, 200, 0);
      push_request(ACT_OFFER, 2043, 2045, 201, 0);
      push_request(ACT_READ, 0, 0, 0, 0);
      push_request(ACT_READ, 0, 0, 0, 1);
      push_request(ACT_READ, 2047, 2047, 255, 2);
      push_request(ACT_READ, 0, 0, 0, 3);
      push_request(ACT_READ, 0, 0, 0, 1023);
      push_request(ACT_SPARE, 0, 0, 0, 0);
      push_request(ACT_CLEAR, 2047, 2047, 255, 1023);
      push_request(ACT_READ, 0, 0, 0, 0);
      apply_setting(8'd0, 6'd0);
      push_request(ACT_OFFER, 1024, 1024, 1, 0);
      push_request(ACT_OFFER, 1024, 1024, 2, 0);
      push_request(ACT_OFFER, 1024, 1024, 0, 0);
      apply_setting(8'd255, 6'd63);
      push_request(ACT_OFFER, 1024, 1024, 255, 0);
      apply_setting(8'd0, 6'd63);
      push_request(ACT_OFFER, 1060, 1060, 200, 0);
      push_request(ACT_OFFER, 1000, 1000, 100, 0);

      // fill the table with distinct points, then probe it while full
      sender_gaps = 1'b0;
      apply_setting(8'd0, 6'd1);
      push_request(ACT_CLEAR, 0, 0, 0, 0);
      for (i = 0; i < MAX_KEYPOINTS; i++) begin
         fill_x[i] = {i[4:0], 1'b0, 5'($urandom)};
         fill_y[i] = {i[9:5], 1'b0, 5'($urandom)};
         push_request(ACT_OFFER, fill_x[i], fill_y[i], RESP_BITS'($urandom_range(1, 254)),
            SLOT_OUT_BITS'($urandom));
      end
      sender_gaps = 1'b1;
      for (i = 0; i < 3; i++) begin
         push_request(ACT_OFFER, {5'($urandom), 1'b1, 5'($urandom)},
            {5'($urandom), 1'b1, 5'($urandom)}, RESP_BITS'($urandom_range(1, 255)), 0);
      end
      k = $urandom_range(0, MAX_KEYPOINTS - 1);
      push_request(ACT_OFFER, fill_x[k], fill_y[k], 1, 0);
      push_request(ACT_OFFER, fill_x[k], fill_y[k], 255, 0);
      push_request(ACT_OFFER, fill_x[MAX_KEYPOINTS-1], fill_y[MAX_KEYPOINTS-1], 255, 0);
      push_request(ACT_READ, 0, 0, 0, 10'd1023);
      push_request(ACT_READ, 0, 0, 0, 0);
      push_request(ACT_READ, 0, 0, 0, SLOT_OUT_BITS'(k));
      push_request(ACT_CLEAR, 0, 0, 0, 0);

      for (i = 0; i < 6; i++) begin
         case (i)
            0: begin thr = 8'd0;   diam = 6'd63; end
            1: begin thr = 8'd255; diam = 6'd1;  end
            2: begin thr = 8'd100; diam = 6'd6;  end
            3: begin thr = 8'd40;  diam = 6'd0;  end
            4: begin thr = 8'd180; diam = 6'd20; end
            default: begin
               thr  = RESP_BITS'($urandom_range(0, 255));
               diam = DIAM_BITS'($urandom_range(1, 63));
            end
         endcase
         if (i == 5) begin
            sender_gaps     = 1'b0;
            receiver_stalls = 1'b0;
         end
         apply_setting(thr, diam);
         random_phase(105, int'(diam) + 4);
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
